[hw/rtl/spe_pkg.sv]
package spe_pkg;

	localparam int unsigned MaxStars = 64;
	localparam logic [15:0] LfsrMask = 16'hB400;

	localparam logic [2:0] RegCenterX   = 3'd0;
	localparam logic [2:0] RegCenterY   = 3'd1;
	localparam logic [2:0] RegSeed      = 3'd2;
	localparam logic [2:0] RegCruise    = 3'd3;
	localparam logic [2:0] RegBoost     = 3'd4;
	localparam logic [2:0] RegMegaboost = 3'd5;
	localparam logic [2:0] RegTiltShift = 3'd6;

	typedef struct packed {
		logic [7:0] speed;
		logic [7:0] player_x;
		logic [7:0] player_y;
	} tick_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_DIV,
		ST_OUT
	} back_state_t;

	function automatic logic [15:0] lfsr_next(input logic [15:0] s);
		logic [15:0] n;
		n = s >> 1;
		if (s[0]) begin
			n = n ^ LfsrMask;
		end
		return n;
	endfunction

	function automatic logic [7:0] tilt_step(input logic [12:0] v, input logic [3:0] sh);
		logic signed [12:0] r;
		r = $signed(v) >>> sh;
		return r[7:0];
	endfunction

	// 256 is 1 mod 255, so fold the two bytes and reduce the sum (0..510)
	function automatic logic [7:0] mod255(input logic [15:0] v);
		logic [8:0] s;
		logic [7:0] m;
		s = {1'b0, v[15:8]} + {1'b0, v[7:0]};
		if (s >= 9'd510) begin
			m = 8'd0;
		end else if (s >= 9'd255) begin
			m = 8'(s - 9'd255);
		end else begin
			m = s[7:0];
		end
		return m;
	endfunction

endpackage

[hw/rtl/spe_ram.sv]
module spe_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/spe_front.sv]
module spe_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    buttons,
	input  logic [12:0]   tilt_x,
	input  logic [12:0]   tilt_y,
	input  logic [5:0]    cruise_speed,
	input  logic [5:0]    boost_speed,
	input  logic [5:0]    megaboost_speed,
	input  logic [3:0]    tilt_shift,
	output logic          q_valid,
	input  logic          q_ready,
	output spe_pkg::tick_t q_data
);
	logic [7:0] speed_q, px_q, py_q;
	logic [7:0] target, nspeed, npx, npy;
	spe_pkg::tick_t fifo_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;

	always_comb begin
		if (buttons[0]) target = {2'b0, megaboost_speed};
		else if (buttons[1]) target = {2'b0, boost_speed};
		else if (buttons[2]) target = 8'd0;
		else target = {2'b0, cruise_speed};
		if (target > speed_q) nspeed = speed_q + 8'd1;
		else if (target < speed_q) nspeed = speed_q - 8'd1;
		else nspeed = speed_q;
		npx = px_q + spe_pkg::tilt_step(tilt_x, tilt_shift);
		npy = py_q - spe_pkg::tilt_step(tilt_y, tilt_shift);
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			px_q <= '0;
			py_q <= '0;
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				speed_q <= nspeed;
				px_q <= npx;
				py_q <= npy;
				wr_q <= ~wr_q;
			end
			if (q_valid && q_ready) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			fifo_q[wr_q] <= '{speed: nspeed, player_x: npx, player_y: npy};
		end
	end
endmodule

[hw/rtl/spe_back.sv]
module spe_back #(
	parameter int NumStars = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  spe_pkg::tick_t q_data,
	input  logic [7:0]    center_x,
	input  logic [7:0]    center_y,
	input  logic          seed_we,
	input  logic [15:0]   seed,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [5:0]    star_number,
	output logic [15:0]   pixel_x,
	output logic [15:0]   pixel_y,
	output logic          last
);
	localparam int Aw = $clog2(spe_pkg::MaxStars);

	spe_pkg::back_state_t state_q, state_d;
	spe_pkg::tick_t tick_q;
	logic [Aw-1:0] idx_q;
	logic [Aw-1:0] idx_nx, raddr_d;
	logic [NumStars-1:0] vld_q;
	logic [15:0] rnd_q;
	logic [7:0] rx, ry, rd_raw, sx_q, sy_q, dep_q;
	logic [7:0] sx, sy, sd;
	logic we;
	logic [15:0] r1, r2, r3;
	logic [15:0] mag_x_q, mag_y_q, quo_x_q, quo_y_q;
	logic neg_x_q, neg_y_q;
	logic [8:0] rem_x_q, rem_y_q;
	logic [4:0] bit_q;
	logic [15:0] px_q, py_q;
	logic [7:0] dx, dy, den;
	logic [8:0] tx, ty;

	assign sx = vld_q[idx_q] ? rx : 8'd0;
	assign sy = vld_q[idx_q] ? ry : 8'd0;
	assign sd = vld_q[idx_q] ? rd_raw : 8'd0;
	assign r1 = spe_pkg::lfsr_next(rnd_q);
	assign r2 = spe_pkg::lfsr_next(r1);
	assign r3 = spe_pkg::lfsr_next(r2);

	// registered read: fetch the next star while the current beat waits
	assign idx_nx = (idx_q == Aw'(NumStars - 1)) ? '0 : idx_q + Aw'(1);
	assign raddr_d = (state_q == spe_pkg::ST_OUT) ? idx_nx : idx_q;

	spe_ram #(.Width(8), .Depth(spe_pkg::MaxStars)) u_x (.clk, .we, .waddr(idx_q),
		.wdata(sx_q), .raddr(raddr_d), .rdata(rx));
	spe_ram #(.Width(8), .Depth(spe_pkg::MaxStars)) u_y (.clk, .we, .waddr(idx_q),
		.wdata(sy_q), .raddr(raddr_d), .rdata(ry));
	spe_ram #(.Width(8), .Depth(spe_pkg::MaxStars)) u_d (.clk, .we, .waddr(idx_q),
		.wdata(dep_q), .raddr(raddr_d), .rdata(rd_raw));

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		we = 1'b0;
		case (state_q)
			spe_pkg::ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) state_d = spe_pkg::ST_READ;
			end
			spe_pkg::ST_READ: state_d = spe_pkg::ST_UPDATE;
			spe_pkg::ST_UPDATE: state_d = spe_pkg::ST_DIV;
			spe_pkg::ST_DIV: begin
				if (bit_q == 5'd16) begin
					we = 1'b1;
					state_d = spe_pkg::ST_OUT;
				end
			end
			spe_pkg::ST_OUT: begin
				if (out_ready) begin
					if (idx_q == Aw'(NumStars - 1)) state_d = spe_pkg::ST_IDLE;
					else state_d = spe_pkg::ST_READ;
				end
			end
			default: state_d = spe_pkg::ST_IDLE;
		endcase
	end

	assign dx = sx_q - tick_q.player_x;
	assign dy = sy_q - tick_q.player_y;
	assign den = (dep_q == 8'd0) ? 8'd1 : dep_q;
	assign tx = {rem_x_q[7:0], mag_x_q[15]};
	assign ty = {rem_y_q[7:0], mag_y_q[15]};

	assign out_valid = (state_q == spe_pkg::ST_OUT);
	assign star_number = 6'(idx_q);
	assign pixel_x = px_q;
	assign pixel_y = py_q;
	assign last = (idx_q == Aw'(NumStars - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spe_pkg::ST_IDLE;
			idx_q <= '0;
			vld_q <= '0;
			rnd_q <= 16'd1;
			bit_q <= '0;
		end else begin
			state_q <= state_d;
			if (seed_we) rnd_q <= (seed == 16'd0) ? 16'd1 : seed;
			else if ((state_q == spe_pkg::ST_READ) && (sd <= tick_q.speed)) rnd_q <= r3;
			case (state_q)
				spe_pkg::ST_IDLE: idx_q <= '0;
				spe_pkg::ST_UPDATE: bit_q <= '0;
				spe_pkg::ST_DIV: begin
					if (bit_q != 5'd16) bit_q <= bit_q + 5'd1;
					else vld_q[idx_q] <= 1'b1;
				end
				spe_pkg::ST_OUT: begin
					if (out_ready) idx_q <= idx_nx;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			spe_pkg::ST_IDLE: begin
				if (q_valid) tick_q <= q_data;
			end
			spe_pkg::ST_READ: begin
				if (sd <= tick_q.speed) begin
					sx_q <= r1[7:0];
					sy_q <= r2[7:0];
					dep_q <= spe_pkg::mod255(r3) + 8'd1;
				end else begin
					sx_q <= sx;
					sy_q <= sy;
					dep_q <= sd - tick_q.speed;
				end
			end
			spe_pkg::ST_UPDATE: begin
				neg_x_q <= ~dx[7];
				neg_y_q <= ~dy[7];
				mag_x_q <= dx[7] ? {1'b0, dx[6:0], 8'd0} : {(8'd128 - dx), 8'd0};
				mag_y_q <= dy[7] ? {1'b0, dy[6:0], 8'd0} : {(8'd128 - dy), 8'd0};
				rem_x_q <= '0;
				rem_y_q <= '0;
				quo_x_q <= '0;
				quo_y_q <= '0;
			end
			spe_pkg::ST_DIV: begin
				if (bit_q != 5'd16) begin
					mag_x_q <= mag_x_q << 1;
					mag_y_q <= mag_y_q << 1;
					if (tx >= {1'b0, den}) begin
						rem_x_q <= tx - {1'b0, den};
						quo_x_q <= {quo_x_q[14:0], 1'b1};
					end else begin
						rem_x_q <= tx;
						quo_x_q <= {quo_x_q[14:0], 1'b0};
					end
					if (ty >= {1'b0, den}) begin
						rem_y_q <= ty - {1'b0, den};
						quo_y_q <= {quo_y_q[14:0], 1'b1};
					end else begin
						rem_y_q <= ty;
						quo_y_q <= {quo_y_q[14:0], 1'b0};
					end
				end else begin
					px_q <= (neg_x_q ? (16'd0 - quo_x_q) : quo_x_q) + {8'd0, center_x};
					py_q <= (neg_y_q ? (16'd0 - quo_y_q) : quo_y_q) + {8'd0, center_y};
				end
			end
			default: ;
		endcase
	end
endmodule

[hw/rtl/starfield_projection_engine_unit.sv]
// Starfield projection engine. One input beat is a frame tick; it yields
// NumStars output beats, one per star in order, tlast on the final one. Each
// star passes through a RAM read, an update, a 16-step restoring division
// of both axes side by side, and output. Ticks queue two deep ahead of the
// star walk.
module starfield_projection_engine_unit #(
	parameter int NumStars = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // up, select, down, tilt_x[12:0], tilt_y[12:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // star_number[5:0], pixel_x[15:0], pixel_y[15:0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [7:0] cx_q, cy_q;
	logic [15:0] seed_q;
	logic [5:0] cruise_q, boost_q, mega_q;
	logic [3:0] tsh_q;
	logic wr;
	logic [2:0] ra;
	logic qv, qr;
	spe_pkg::tick_t qd;
	logic [5:0] sn;
	logic [15:0] pxo, pyo;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign ra = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= 8'd72;
			cy_q <= 8'd93;
			seed_q <= 16'd1;
			cruise_q <= 6'd1;
			boost_q <= 6'd16;
			mega_q <= 6'd32;
			tsh_q <= 4'd6;
		end else if (wr) begin
			case (ra)
				spe_pkg::RegCenterX: cx_q <= pwdata[7:0];
				spe_pkg::RegCenterY: cy_q <= pwdata[7:0];
				spe_pkg::RegSeed: seed_q <= pwdata[15:0];
				spe_pkg::RegCruise: cruise_q <= pwdata[5:0];
				spe_pkg::RegBoost: boost_q <= pwdata[5:0];
				spe_pkg::RegMegaboost: mega_q <= pwdata[5:0];
				spe_pkg::RegTiltShift: tsh_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ra)
			spe_pkg::RegCenterX: prdata = {24'd0, cx_q};
			spe_pkg::RegCenterY: prdata = {24'd0, cy_q};
			spe_pkg::RegSeed: prdata = {16'd0, seed_q};
			spe_pkg::RegCruise: prdata = {26'd0, cruise_q};
			spe_pkg::RegBoost: prdata = {26'd0, boost_q};
			spe_pkg::RegMegaboost: prdata = {26'd0, mega_q};
			spe_pkg::RegTiltShift: prdata = {28'd0, tsh_q};
			default: prdata = '0;
		endcase
	end

	spe_front u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.buttons(s_tdata[2:0]), .tilt_x(s_tdata[15:3]), .tilt_y(s_tdata[28:16]),
		.cruise_speed(cruise_q), .boost_speed(boost_q), .megaboost_speed(mega_q),
		.tilt_shift(tsh_q),
		.q_valid(qv), .q_ready(qr), .q_data(qd)
	);

	spe_back #(.NumStars(NumStars)) u_back (
		.clk, .arst_n,
		.q_valid(qv), .q_ready(qr), .q_data(qd),
		.center_x(cx_q), .center_y(cy_q),
		.seed_we(wr && (ra == spe_pkg::RegSeed)), .seed(pwdata[15:0]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.star_number(sn), .pixel_x(pxo), .pixel_y(pyo), .last(m_tlast)
	);

	assign m_tdata = {2'd0, pyo, pxo, sn};
endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	localparam int NStars = 64;
	localparam int StallLimit = 20000;
	localparam logic [2:0] RegUnused = 3'd7;

	typedef struct packed {
		logic [5:0]  star;
		logic [15:0] px;
		logic [15:0] py;
		logic        last;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	starfield_projection_engine_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [7:0]  cx, cy, cruise, boost, mega;
	logic [3:0]  tshift;
	logic [7:0]  sx [NStars];
	logic [7:0]  sy [NStars];
	logic [7:0]  sz [NStars];
	logic [7:0]  plx, ply, speed;
	logic [15:0] rng;

	pixel_t pending_pixels[$];
	int     errors;
	int     idle_cycles;
	bit     long_hold;
	bit     hold_taken = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [15:0] rng_draw();
		logic [15:0] s;
		s = rng >> 1;
		if (rng[0]) begin
			s = s ^ 16'hB400;
		end
		rng = s;
		return s;
	endfunction

	function automatic logic [7:0] tilt_delta(input logic [12:0] v, input logic [3:0] sh);
		int t;
		t = $signed(v);
		t = t >>> sh;
		return t[7:0];
	endfunction

	function automatic logic [15:0] project_axis(input logic [7:0] pos, input logic [7:0] pl,
			input logic [7:0] z, input logic [7:0] c);
		int d, q;
		logic [7:0] w;
		w = pos - pl;
		d = int'(w) - 128;
		q = (d * 256) / ((z == 8'd0) ? 1 : int'(z));
		q = q + int'(c);
		return q[15:0];
	endfunction

	task automatic predictor_reset();
		cx = 8'd72; cy = 8'd93; cruise = 8'd1; boost = 8'd16; mega = 8'd32;
		tshift = 4'd6; rng = 16'd1; plx = '0; ply = '0; speed = '0;
		for (int i = 0; i < NStars; i++) begin
			sx[i] = '0; sy[i] = '0; sz[i] = '0;
		end
	endtask

	task automatic predict_tick(input logic [31:0] d);
		logic [7:0]  target;
		logic [15:0] r;
		pixel_t      p;
		if (d[0]) begin
			target = mega;
		end else if (d[1]) begin
			target = boost;
		end else if (d[2]) begin
			target = 8'd0;
		end else begin
			target = cruise;
		end
		if (target > speed) begin
			speed = speed + 8'd1;
		end else if (target < speed) begin
			speed = speed - 8'd1;
		end
		for (int i = 0; i < NStars; i++) begin
			if (sz[i] <= speed) begin
				r = rng_draw(); sx[i] = r[7:0];
				r = rng_draw(); sy[i] = r[7:0];
				r = rng_draw(); sz[i] = 8'((r % 255) + 1);
			end else begin
				sz[i] = sz[i] - speed;
			end
		end
		plx = plx + tilt_delta(d[15:3], tshift);
		ply = ply - tilt_delta(d[28:16], tshift);
		for (int i = 0; i < NStars; i++) begin
			p.star = i[5:0];
			p.px = project_axis(sx[i], plx, sz[i], cx);
			p.py = project_axis(sy[i], ply, sz[i], cy);
			p.last = (i == NStars - 1);
			pending_pixels.push_back(p);
		end
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			spe_pkg::RegCenterX: cx = val[7:0];
			spe_pkg::RegCenterY: cy = val[7:0];
			spe_pkg::RegSeed: rng = (val[15:0] == 16'd0) ? 16'd1 : val[15:0];
			spe_pkg::RegCruise: cruise = {2'b00, val[5:0]};
			spe_pkg::RegBoost: boost = {2'b00, val[5:0]};
			spe_pkg::RegMegaboost: mega = {2'b00, val[5:0]};
			spe_pkg::RegTiltShift: tshift = val[3:0];
			default: ;
		endcase
	endtask

	// tvalid stays high into the next beat of a burst; gaps and drain drop it
	task automatic send_tick(input logic [2:0] btn, input logic [12:0] tx, input logic [12:0] ty);
		logic [31:0] d;
		d = {3'b000, ty, tx, btn};
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		predict_tick(d);
	endtask

	task automatic sender_gap();
		int g;
		g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic test_button_and_tilt_extremes();
		send_tick(3'b000, 13'h0000, 13'h0000);
		send_tick(3'b001, 13'h0FFF, 13'h1000);
		send_tick(3'b010, 13'h1000, 13'h0FFF);
		send_tick(3'b100, 13'h1FFF, 13'h0001);
		send_tick(3'b111, 13'h1555, 13'h0AAA);
		send_tick(3'b110, 13'h0AAA, 13'h1555);
		send_tick(3'b101, 13'h0000, 13'h1FFF);
		send_tick(3'b011, 13'h0FFF, 13'h0FFF);
		drain();
	endtask

	task automatic test_register_extremes();
		reg_write(spe_pkg::RegCenterX, 32'd0);
		reg_write(spe_pkg::RegCenterY, 32'd255);
		reg_write(spe_pkg::RegSeed, 32'd0);
		reg_write(spe_pkg::RegCruise, 32'd63);
		reg_write(spe_pkg::RegBoost, 32'd0);
		reg_write(spe_pkg::RegMegaboost, 32'd63);
		reg_write(spe_pkg::RegTiltShift, 32'd15);
		reg_write(RegUnused, 32'hFFFF_FFFF);
		for (int i = 0; i < 6; i++) begin
			send_tick(3'b000, 13'h1000, 13'h0FFF);
		end
		send_tick(3'b010, 13'h0FFF, 13'h1000);
		drain();
		reg_write(spe_pkg::RegCenterX, 32'd255);
		reg_write(spe_pkg::RegCenterY, 32'd0);
		reg_write(spe_pkg::RegSeed, 32'hFFFF);
		reg_write(spe_pkg::RegTiltShift, 32'd0);
		reg_write(spe_pkg::RegCruise, 32'd0);
		for (int i = 0; i < 4; i++) begin
			send_tick(3'b001, 13'h0FFF, 13'h1000);
		end
		send_tick(3'b100, 13'h1000, 13'h0FFF);
		drain();
	endtask

	task automatic test_random_ticks(input int n);
		for (int i = 0; i < n; i++) begin
			send_tick(3'($urandom_range(0, 7)), 13'($urandom), 13'($urandom));
			sender_gap();
		end
		drain();
	endtask

	task automatic test_backpressure();
		long_hold = 1'b1;
		for (int i = 0; i < 6; i++) begin
			send_tick(3'($urandom_range(0, 7)), 13'($urandom), 13'($urandom));
		end
		drain();
	endtask

	task automatic random_settings();
		reg_write(spe_pkg::RegCenterX, $urandom_range(0, 255));
		reg_write(spe_pkg::RegCenterY, $urandom_range(0, 255));
		reg_write(spe_pkg::RegSeed, $urandom_range(1, 65535));
		reg_write(spe_pkg::RegCruise, $urandom_range(0, 63));
		reg_write(spe_pkg::RegBoost, $urandom_range(0, 63));
		reg_write(spe_pkg::RegMegaboost, $urandom_range(0, 63));
		reg_write(spe_pkg::RegTiltShift, $urandom_range(0, 12));
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (long_hold && !hold_taken) begin
			hold_taken <= 1'b1;
			m_tready <= 1'b0;
			repeat (3000) @(posedge clk);
		end else begin
			case ($urandom_range(0, 9))
				0, 1: m_tready <= 1'b0;
				default: m_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		pixel_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[5:0], m_tdata[21:6], m_tdata[37:22], m_tlast};
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel %h", $time, got);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (got.star !== want.star) begin
					$display("%0t: star exp %0d got %0d", $time, want.star, got.star);
					errors++;
				end
				if (got.px !== want.px) begin
					$display("%0t: pixel_x exp %h got %h", $time, want.px, got.px);
					errors++;
				end
				if (got.py !== want.py) begin
					$display("%0t: pixel_y exp %h got %h", $time, want.py, got.py);
					errors++;
				end
				if (got.last !== want.last) begin
					$display("%0t: last exp %b got %b", $time, want.last, got.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles > StallLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		long_hold = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		predictor_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_button_and_tilt_extremes();
		test_register_extremes();
		test_backpressure();
		for (int k = 0; k < 5; k++) begin
			random_settings();
			test_random_ticks(45);
		end
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
